[sv/sha_pkg.sv]
// sha_pkg: shared constants, types and round functions for the sha-256 hasher
// no dependencies
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned IdxW       = 6;

  localparam logic        KIND_BYTE = 1'b0;
  localparam logic        KIND_END  = 1'b1;
  localparam logic [7:0]  PAD_BYTE  = 8'h80;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  // controller to datapath commands
  typedef struct packed {
    logic            init;      // load initial hash values
    logic            wr_byte;   // write a byte into the block buffer
    logic [IdxW-1:0] wr_addr;
    logic [1:0]      wr_src;    // byte source
    logic            start;     // load working vars from hash
    logic            round;     // perform one round
    logic [IdxW-1:0] rnd;
    logic            finish;    // add working vars into hash
  } sha_cmd_t;

  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(input logic [IdxW-1:0] i);
    word_t k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[sv/sha_if.sv]
// sha_if: valid/ready channel interfaces for the hasher
// depends on nothing
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink (input valid, digest_word, word_index, last, output ready);
endinterface

[sv/sha_datapath.sv]
// sha_datapath: block buffer as 16-word schedule window, round logic, hash state
// depends on sha_pkg
module sha_datapath (
  input  logic                clk,
  input  sha_pkg::sha_cmd_t   cmd,
  input  logic [7:0]          data_byte,
  input  logic [63:0]         bit_len,
  output sha_pkg::hash_t      hash
);

  sha_pkg::word_t [15:0] w_r, w_nxt;
  sha_pkg::hash_t        h_r, h_nxt;
  sha_pkg::word_t [7:0]  v_r, v_nxt;

  logic [7:0] byte_in;
  logic [2:0] len_sel;
  sha_pkg::word_t s0, s1, wnew, t1, t2, e, a, wi;

  assign len_sel = cmd.wr_addr[2:0];

  always_comb begin
    unique case (cmd.wr_src)
      sha_pkg::SRC_DATA: byte_in = data_byte;
      sha_pkg::SRC_PAD:  byte_in = sha_pkg::PAD_BYTE;
      sha_pkg::SRC_ZERO: byte_in = 8'h00;
      default:           byte_in = bit_len[8'(7 - len_sel) * 8 +: 8];
    endcase
  end

  always_comb begin
    wi   = w_r[0];
    s0   = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = s1 + w_r[9] + s0 + w_r[0];
    e    = v_r[4];
    a    = v_r[0];
    t1   = v_r[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
         + ((e & v_r[5]) ^ (~e & v_r[6])) + sha_pkg::round_k(cmd.rnd) + wi;
    t2   = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
         + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

    w_nxt = w_r;
    v_nxt = v_r;
    h_nxt = h_r;
    if (cmd.wr_byte) begin
      w_nxt[cmd.wr_addr[5:2]][8'(3 - cmd.wr_addr[1:0]) * 8 +: 8] = byte_in;
    end
    if (cmd.start) v_nxt = h_r;
    if (cmd.round) begin
      // window shifts down one word per round
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[15] = wnew;
      v_nxt = {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
    end
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) h_nxt[i] = h_r[i] + v_r[i];
    end
    if (cmd.init) h_nxt = sha_pkg::INIT_H;
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
    h_r <= h_nxt;
  end

  assign hash = h_r;

endmodule

[sv/sha_ctrl.sv]
// sha_ctrl: sequencer for byte intake, padding, rounds and digest output
// depends on sha_pkg
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_idx,
  output logic [63:0]       bit_len,
  output sha_pkg::sha_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;   // bytes held / pad write pointer
  logic [5:0]  rnd_r, rnd_nxt;
  logic [63:0] len_r, len_nxt;
  logic        ending_r, ending_nxt;  // message end seen
  logic        lenblk_r, lenblk_nxt;  // current pad block carries length
  logic [2:0]  oidx_r, oidx_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = oidx_r;
  assign bit_len   = len_r;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    rnd_nxt    = rnd_r;
    len_nxt    = len_r;
    ending_nxt = ending_r;
    lenblk_nxt = lenblk_r;
    oidx_nxt   = oidx_r;
    cmd        = '0;
    cmd.wr_addr = fill_r;
    cmd.rnd     = rnd_r;
    cmd.wr_src  = sha_pkg::SRC_DATA;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr_byte = 1'b1;
          if (in_kind == sha_pkg::KIND_BYTE) begin
            fill_nxt = fill_r + 6'd1;
            len_nxt  = len_r + 64'd8;
            if (fill_r == 6'd63) state_nxt = S_START;
          end else begin
            cmd.wr_src = sha_pkg::SRC_PAD;
            ending_nxt = 1'b1;
            lenblk_nxt = (fill_r < 6'd56);
            fill_nxt   = fill_r + 6'd1;
            state_nxt  = (fill_r == 6'd63) ? S_START : S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.wr_byte = 1'b1;
        cmd.wr_src  = (lenblk_r && fill_r >= 6'd56) ? sha_pkg::SRC_LEN
                                                    : sha_pkg::SRC_ZERO;
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) state_nxt = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        fill_nxt   = '0;
        if (!ending_r) begin
          state_nxt = S_IDLE;
        end else if (!lenblk_r) begin
          lenblk_nxt = 1'b1;
          state_nxt  = S_PAD;
        end else begin
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.init   = 1'b1;
            len_nxt    = '0;
            ending_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (!rst_n) cmd.init = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      rnd_r    <= '0;
      len_r    <= '0;
      ending_r <= 1'b0;
      lenblk_r <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      len_r    <= len_nxt;
      ending_r <= ending_nxt;
      lenblk_r <= lenblk_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

endmodule

[sv/sha256_stream_hasher_top.sv]
// sha256_stream_hasher_top: byte-stream sha-256 hasher top level
// depends on sha_pkg, sha_if, sha_ctrl, sha_datapath
//
// Takes one message word (byte) per cycle while idle; each 64th byte starts a
// compression of 64 rounds, one round a cycle through the single round unit,
// between a setup state and a hash update state. An end word writes the
// 0x80 pad, then fills zeros and the big-endian bit count one byte a cycle,
// compresses once or twice, and then presents the eight digest words, index
// 0 first, last set on index 7, one per accepted output cycle. Input is not
// taken while padding, compressing or emitting. After the last digest word
// the hash, length and fill count return to initial values.
module sha256_stream_hasher_top (
  input logic        clk,
  input logic        rst_n,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::hash_t    hash;
  logic [63:0]       bit_len;
  logic [2:0]        oidx;

  // sequencer
  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_idx   (oidx),
    .bit_len   (bit_len),
    .cmd       (cmd)
  );

  // message window, round unit and hash state
  sha_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .bit_len   (bit_len),
    .hash      (hash)
  );

  // digest words straight from the hash registers
  assign out_ch.digest_word = hash[oidx];
  assign out_ch.word_index  = oidx;
  assign out_ch.last        = (oidx == 3'd7);

`ifndef NO_ASSERTIONS
  // no input taken while a digest is presented
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("in and out both open");
  // a stalled digest word keeps its index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(oidx)))
    else $error("digest index moved under stall");
  // last word leaves output state
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("not idle after last digest word");
`endif

endmodule
